// ===== hw/rtl/cosol_pkg.sv =====
package cosol_pkg;

    localparam int DEPTH      = 64;
    localparam int VALUE_BITS = 32;
    localparam int COUNT_BITS = 16;

    localparam int IDX_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LEN_BITS   = $clog2(DEPTH + 1);
    localparam int ENTRY_BITS = VALUE_BITS + COUNT_BITS;
    localparam int IN_BITS    = 32;
    localparam int POS_BITS   = 6;
    localparam int STAT_BITS  = 2;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    localparam logic [STAT_BITS-1:0] ST_APPENDED = 2'd0;
    localparam logic [STAT_BITS-1:0] ST_FOUND    = 2'd1;
    localparam logic [STAT_BITS-1:0] ST_MISS     = 2'd2;
    localparam logic [STAT_BITS-1:0] ST_FULL     = 2'd3;

endpackage

// ===== hw/rtl/cosol_req_if.sv =====
interface cosol_req_if import cosol_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic                       command;
    logic signed [IN_BITS-1:0]  value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

// ===== hw/rtl/cosol_rsp_if.sv =====
interface cosol_rsp_if import cosol_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [STAT_BITS-1:0]   status;
    logic [POS_BITS-1:0]    position;

    modport source (output valid, output status, output position, input ready);
    modport sink   (input valid, input status, input position, output ready);
endinterface

// ===== hw/rtl/cosol_ram.sv =====
module cosol_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/count_ordered_self_organizing_list.sv =====
// Count-ordered self-organising list.
// req channel: command (append or search) and value. rsp channel: status and
// position, exactly one response per request.
// Append writes the new entry on acceptance, then responds. A search reads the
// entry store through its single registered read port, reading and then
// checking each entry from the head until a hit at position p or the tail. A
// hit that promotes its entry adds a predecessor check, a scan from the head
// for the insertion point j, a shift of entries j to p - 1 one place towards
// the tail, and a final write of the entry at j. One request is worked on at
// a time; req.ready is high only while the sequencer is idle.
// The response sits in an output register, so a new request is accepted while
// the previous response waits; a request that finishes while rsp is stalled
// holds in the response state until the register frees.
// Reset empties the list at once (length zero); no clearing pass is needed as
// only entries below the length are ever read.
module count_ordered_self_organizing_list import cosol_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    cosol_req_if.sink       req,
    cosol_rsp_if.source     rsp
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SCAN_RD  = 4'd1;
    localparam logic [3:0] S_SCAN_CHK = 4'd2;
    localparam logic [3:0] S_PREV_RD  = 4'd3;
    localparam logic [3:0] S_PREV_CHK = 4'd4;
    localparam logic [3:0] S_FIND_RD  = 4'd5;
    localparam logic [3:0] S_FIND_CHK = 4'd6;
    localparam logic [3:0] S_SHIFT_RD = 4'd7;
    localparam logic [3:0] S_SHIFT_WR = 4'd8;
    localparam logic [3:0] S_PLACE    = 4'd9;
    localparam logic [3:0] S_RESP     = 4'd10;

    logic [3:0]             state_reg, state_next;
    logic [LEN_BITS-1:0]    len_reg, len_next;
    logic                   out_valid_reg, out_valid_next;
    logic [STAT_BITS-1:0]   out_status_reg, out_status_next;
    logic [POS_BITS-1:0]    out_pos_reg, out_pos_next;

    logic [VALUE_BITS-1:0]  key_reg, key_next;
    logic [COUNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [IDX_BITS-1:0]    idx_reg, idx_next;
    logic [IDX_BITS-1:0]    hit_reg, hit_next;
    logic [IDX_BITS-1:0]    j_reg, j_next;
    logic [IDX_BITS-1:0]    k_reg, k_next;
    logic [STAT_BITS-1:0]   status_reg, status_next;

    logic                   we;
    logic [IDX_BITS-1:0]    wr_addr, rd_addr;
    logic [ENTRY_BITS-1:0]  wr_data, rd_data;
    logic [VALUE_BITS-1:0]  rd_value, in_key;
    logic [COUNT_BITS-1:0]  rd_count, cnt_inc;
    logic [IN_BITS-1:0]     value_u;

    assign value_u  = req.value;
    assign in_key   = VALUE_BITS'(value_u);
    assign rd_value = rd_data[ENTRY_BITS-1 -: VALUE_BITS];
    assign rd_count = rd_data[COUNT_BITS-1:0];
    assign cnt_inc  = (rd_count == COUNT_MAX) ? rd_count : rd_count + COUNT_BITS'(1);

    cosol_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign req.ready    = (state_reg == S_IDLE);
    assign rsp.valid    = out_valid_reg;
    assign rsp.status   = out_status_reg;
    assign rsp.position = out_pos_reg;

    always_comb
    begin
        state_next      = state_reg;
        len_next        = len_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_pos_next    = out_pos_reg;
        key_next        = key_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        hit_next        = hit_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        status_next     = status_reg;
        we              = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;
        rd_addr         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    key_next = in_key;
                    hit_next = '0;
                    if (req.command == CMD_APPEND)
                    begin
                        if (len_reg == LEN_BITS'(DEPTH))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            we          = 1'b1;
                            wr_addr     = len_reg[IDX_BITS-1:0];
                            wr_data     = {in_key, {COUNT_BITS{1'b0}}};
                            len_next    = len_reg + LEN_BITS'(1);
                            status_next = ST_APPENDED;
                        end
                        state_next = S_RESP;
                    end
                    else if (len_reg == '0)
                    begin
                        status_next = ST_MISS;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = S_SCAN_RD;
                    end
                end
            end

            S_SCAN_RD:
            begin
                rd_addr    = idx_reg;
                state_next = S_SCAN_CHK;
            end

            S_SCAN_CHK:
            begin
                if (rd_value == key_reg)
                begin
                    hit_next    = idx_reg;
                    status_next = ST_FOUND;
                    cnt_next    = cnt_inc;
                    if (len_reg == LEN_BITS'(1))
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        // store the bumped count in place
                        we      = 1'b1;
                        wr_addr = idx_reg;
                        wr_data = {key_reg, cnt_inc};
                        if (idx_reg == '0)
                        begin
                            state_next = S_RESP;
                        end
                        else
                        begin
                            state_next = S_PREV_RD;
                        end
                    end
                end
                else if (LEN_BITS'(idx_reg) == len_reg - LEN_BITS'(1))
                begin
                    hit_next    = '0;
                    status_next = ST_MISS;
                    state_next  = S_RESP;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_BITS'(1);
                    state_next = S_SCAN_RD;
                end
            end

            S_PREV_RD:
            begin
                rd_addr    = hit_reg - IDX_BITS'(1);
                state_next = S_PREV_CHK;
            end

            S_PREV_CHK:
            begin
                if (rd_count < cnt_reg)
                begin
                    j_next     = '0;
                    state_next = S_FIND_RD;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end

            S_FIND_RD:
            begin
                rd_addr    = j_reg;
                state_next = S_FIND_CHK;
            end

            S_FIND_CHK:
            begin
                // the predecessor qualifies, so this stops by hit - 1
                if (rd_count < cnt_reg)
                begin
                    k_next     = hit_reg;
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    j_next     = j_reg + IDX_BITS'(1);
                    state_next = S_FIND_RD;
                end
            end

            S_SHIFT_RD:
            begin
                rd_addr    = k_reg - IDX_BITS'(1);
                state_next = S_SHIFT_WR;
            end

            S_SHIFT_WR:
            begin
                we      = 1'b1;
                wr_addr = k_reg;
                wr_data = rd_data;
                k_next  = k_reg - IDX_BITS'(1);
                if (k_reg - IDX_BITS'(1) == j_reg)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    state_next = S_SHIFT_RD;
                end
            end

            S_PLACE:
            begin
                we         = 1'b1;
                wr_addr    = j_reg;
                wr_data    = {key_reg, cnt_reg};
                state_next = S_RESP;
            end

            S_RESP:
            begin
                // hold until the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_pos_next    = POS_BITS'(hit_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_pos_reg    <= out_pos_next;
        key_reg        <= key_next;
        cnt_reg        <= cnt_next;
        idx_reg        <= idx_next;
        hit_reg        <= hit_next;
        j_reg          <= j_next;
        k_reg          <= k_next;
        status_reg     <= status_next;
    end

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_BITS'(DEPTH))
        else $error("list length beyond depth");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.command == CMD_APPEND
            && len_reg != LEN_BITS'(DEPTH))
        |=> len_reg == $past(len_reg) + LEN_BITS'(1))
        else $error("append did not grow the list");

    a_len_stable_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |=> $stable(len_reg))
        else $error("list length changed during a search");

    a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == ST_FOUND) |-> (32'(rsp.position) < 32'(len_reg)))
        else $error("hit position outside the list");

    a_shift_above_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT_RD) |-> (k_reg > j_reg))
        else $error("shift pointer ran past the insertion slot");

endmodule

// ===== sim/tb_count_ordered_self_organizing_list.sv =====
`timescale 1ns / 100ps

module tb_count_ordered_self_organizing_list;
    import cosol_pkg::*;

    localparam int CYCLE_LIMIT   = 6_000_000;
    localparam int RANDOM_ITEMS  = 1700;
    localparam int HOLD_OFF      = 1200;
    localparam int SETTLE_CYCLES = 8 * DEPTH;

    typedef struct packed {
        logic [STAT_BITS-1:0] status;
        logic [POS_BITS-1:0]  position;
    } list_response_t;

    logic clk;
    logic rst_n;

    cosol_req_if req_bus ();
    cosol_rsp_if rsp_bus ();

    count_ordered_self_organizing_list u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // Mirror of the list contents
    logic [VALUE_BITS-1:0] stored_values [DEPTH];
    logic [COUNT_BITS-1:0] stored_counts [DEPTH];
    int                    stored_length = 0;

    list_response_t awaited_responses [$];
    list_response_t expected_response;

    int mismatch_count  = 0;
    int cycle_count     = 0;
    int burst_left      = 0;
    int hold_off_cycles = 0;
    bit sender_idle_on  = 1'b1;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_count_ordered_self_organizing_list: FAIL");
        $finish;
    end

    task automatic report_mismatch(input string detail);
        $display("[%0t] mismatch: %s", $time, detail);
        mismatch_count++;
    endtask

    // Apply one request to the mirrored list and return the response it should give
    function automatic list_response_t apply_list_command(input logic cmd,
                                                          input logic [IN_BITS-1:0] val);
        list_response_t        rsp;
        logic [VALUE_BITS-1:0] key;
        logic [VALUE_BITS-1:0] moved_value;
        logic [COUNT_BITS-1:0] hit_count;
        int                    hit_at;
        int                    slot;
        int                    k;

        key          = val[VALUE_BITS-1:0];
        rsp.position = '0;
        hit_at       = -1;
        if (cmd == CMD_APPEND)
        begin
            if (stored_length >= DEPTH)
            begin
                rsp.status = ST_FULL;
            end
            else
            begin
                stored_values[stored_length] = key;
                stored_counts[stored_length] = '0;
                stored_length++;
                rsp.status = ST_APPENDED;
            end
        end
        else
        begin
            for (k = 0; k < stored_length; k++)
            begin
                if (hit_at < 0 && stored_values[k] == key)
                    hit_at = k;
            end
            if (hit_at < 0)
            begin
                rsp.status = ST_MISS;
            end
            else
            begin
                rsp.status   = ST_FOUND;
                rsp.position = hit_at[POS_BITS-1:0];
                if (stored_length > 1)
                begin
                    hit_count = stored_counts[hit_at];
                    if (hit_count != COUNT_MAX)
                        hit_count++;
                    stored_counts[hit_at] = hit_count;
                    if (hit_at > 0 && stored_counts[hit_at-1] < hit_count)
                    begin
                        // Insert ahead of the first entry from the head with a lower count
                        slot = 0;
                        while (stored_counts[slot] >= hit_count)
                            slot++;
                        moved_value = stored_values[hit_at];
                        for (k = hit_at; k > slot; k--)
                        begin
                            stored_values[k] = stored_values[k-1];
                            stored_counts[k] = stored_counts[k-1];
                        end
                        stored_values[slot] = moved_value;
                        stored_counts[slot] = hit_count;
                    end
                end
            end
        end
        return rsp;
    endfunction

    // Pick a key held in the list; lean towards the tail to provoke moves
    function automatic logic [IN_BITS-1:0] pick_stored_value();
        int idx;

        if ($urandom_range(0, 1) == 0)
            idx = $urandom_range(0, stored_length - 1);
        else
            idx = $urandom_range((stored_length * 3) / 4, stored_length - 1);
        return IN_BITS'(stored_values[idx]);
    endfunction

    // Offer one request; return at the falling edge after it is accepted
    task automatic send_request(input logic cmd, input logic [IN_BITS-1:0] val);
        if (sender_idle_on && burst_left == 0)
        begin
            req_bus.valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 48 : $urandom_range(1, 10);
        end
        req_bus.valid   = 1'b1;
        req_bus.command = cmd;
        req_bus.value   = val;
        do
            @(posedge clk);
        while (!req_bus.ready);
        awaited_responses.push_back(apply_list_command(cmd, val));
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
    endtask

    // Receiver: stall on a rotating random pattern, or hold off when asked
    initial
    begin
        logic [31:0] stall_pattern;
        int          stall_phase;
        int          held;

        stall_pattern = '1;
        stall_phase   = 0;
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                rsp_bus.ready = 1'b0;
                held = 0;
                while (held < hold_off_cycles)
                begin
                    @(negedge clk);
                    held++;
                end
                hold_off_cycles = 0;
            end
            if (stall_phase == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       stall_pattern = '1;
                    1:       stall_pattern = $urandom | $urandom;
                    2:       stall_pattern = $urandom;
                    default: stall_pattern = $urandom & $urandom;
                endcase
            end
            rsp_bus.ready = stall_pattern[stall_phase];
            stall_phase   = (stall_phase + 1) % 32;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (awaited_responses.size() == 0)
            begin
                report_mismatch($sformatf("unexpected response status=%0d position=%0d",
                                          rsp_bus.status, rsp_bus.position));
            end
            else
            begin
                expected_response = awaited_responses.pop_front();
                if (rsp_bus.status !== expected_response.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              rsp_bus.status, expected_response.status));
                if (rsp_bus.position !== expected_response.position)
                    report_mismatch($sformatf("position %0d, expected %0d",
                                              rsp_bus.position, expected_response.position));
            end
        end
    end

    task automatic test_empty_and_single_entry();
        send_request(CMD_SEARCH, 32'h7FFF_FFFF);
        send_request(CMD_APPEND, 32'h7FFF_FFFF);
        // a lone entry must not gain hits
        send_request(CMD_SEARCH, 32'h7FFF_FFFF);
        send_request(CMD_SEARCH, 32'h7FFF_FFFF);
        send_request(CMD_SEARCH, 32'h8000_0000);
        send_request(CMD_APPEND, 32'h8000_0000);
        send_request(CMD_SEARCH, 32'h8000_0000);
        send_request(CMD_SEARCH, 32'h8000_0000);
        send_request(CMD_SEARCH, 32'h7FFF_FFFF);
    endtask

    task automatic test_reordering_and_duplicates();
        send_request(CMD_APPEND, 32'h0000_0000);
        send_request(CMD_APPEND, 32'hFFFF_FFFF);
        send_request(CMD_APPEND, 32'h7FFF_FFFF);
        send_request(CMD_APPEND, 32'h5A5A_A5A5);
        send_request(CMD_SEARCH, 32'h5A5A_A5A5);
        send_request(CMD_SEARCH, 32'h7FFF_FFFF);
        send_request(CMD_SEARCH, 32'hFFFF_FFFF);
        send_request(CMD_SEARCH, 32'h1234_5678);
        send_request(CMD_SEARCH, 32'h0000_0000);
        send_request(CMD_SEARCH, 32'h8000_0000);
        send_request(CMD_SEARCH, 32'h5A5A_A5A5);
    endtask

    task automatic test_fill_to_capacity();
        while (stored_length < DEPTH)
        begin
            if ($urandom_range(0, 99) < 65)
            begin
                if ($urandom_range(0, 7) == 0)
                    send_request(CMD_APPEND, pick_stored_value());
                else
                    send_request(CMD_APPEND, $urandom);
            end
            else
            begin
                send_request(CMD_SEARCH, pick_stored_value());
            end
        end
        repeat (3)
            send_request(CMD_APPEND, $urandom);
        send_request(CMD_SEARCH, IN_BITS'(stored_values[DEPTH-1]));
    endtask

    task automatic test_backpressure();
        sender_idle_on  = 1'b0;
        hold_off_cycles = HOLD_OFF;
        repeat (16)
            send_request(CMD_SEARCH, pick_stored_value());
        sender_idle_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int pick;

        repeat (RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                send_request(CMD_APPEND, $urandom);
            else if (pick < 18 || stored_length == 0)
                send_request(CMD_SEARCH, $urandom);
            else
                send_request(CMD_SEARCH, pick_stored_value());
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        req_bus.valid   = 1'b0;
        req_bus.command = CMD_APPEND;
        req_bus.value   = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_and_single_entry();
        test_reordering_and_duplicates();
        test_fill_to_capacity();
        test_backpressure();
        test_random_traffic();

        req_bus.valid = 1'b0;
        while (awaited_responses.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb_count_ordered_self_organizing_list: PASS");
        else
            $display("tb_count_ordered_self_organizing_list: FAIL");
        $finish;
    end

endmodule
